[sv/prl_pkg.sv]
// Shared types and constants of the per-peer connection rate limiter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // Field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned OUT_W    = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [IDX_W:0]        scan_cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam scan_cnt_t SCAN_END = scan_cnt_t'(TABLE_ENTRIES);
  localparam idx_t      LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

  // Register indexes
  localparam cfg_idx_t REG_RATE_LIMIT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WINDOW     = cfg_idx_t'(1);

  // Register reset values
  localparam logic [COUNT_W-1:0]  RATE_LIMIT_RST = 8'd8;
  localparam logic [WINDOW_W-1:0] WINDOW_RST     = 16'd60;

  // Result codes
  typedef enum logic [OUT_W-1:0] {
    OUT_NEW     = 3'd0,
    OUT_EVICT   = 3'd1,
    OUT_RESTART = 3'd2,
    OUT_COUNTED = 3'd3,
    OUT_REJECT  = 3'd4
  } outcome_t;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  window_start;
  } entry_t;

  // Table access request from the controller
  typedef struct packed {
    logic rd_en;
    idx_t rd_idx;
    logic wr_en;
    idx_t wr_idx;
  } tbl_req_t;

endpackage

`default_nettype wire

[sv/prl_if.sv]
// Valid/ready channel interfaces for connection attempts and verdicts.
// Depends on prl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface prl_attempt_if;
  import prl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] peer_ip;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, output peer_ip, output now_seconds, input ready);
  modport sink   (input valid, input peer_ip, input now_seconds, output ready);
endinterface

interface prl_verdict_if;
  import prl_pkg::*;
  logic             valid;
  logic             ready;
  logic             allowed;
  logic [OUT_W-1:0] outcome;

  modport source (output valid, output allowed, output outcome, input ready);
  modport sink   (input valid, input allowed, input outcome, output ready);
endinterface

`default_nettype wire

[sv/prl_table.sv]
// Entry table: one synchronous memory with a registered read port,
// plus per-entry valid bits so that unwritten entries read as zero. Uses prl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prl_table (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire prl_pkg::tbl_req_t req,
  input  wire prl_pkg::entry_t  wr_data,
  output prl_pkg::entry_t       rd_entry
);
  import prl_pkg::*;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  entry_t                   rd_data;
  logic                     rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= wr_data;
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_idx] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data  <= mem[req.rd_idx];
      rd_valid <= valid[req.rd_idx];
    end
  end

  // Unwritten entries read as the cleared value
  assign rd_entry = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

[sv/per_peer_connection_rate_limiter.sv]
// Per-peer connection rate limiter, fixed window per peer address.
// Each attempt scans the table from entry 0 up to the first matching entry, or over the
// whole 64-entry table when no entry matches, then writes back and registers the verdict.
// One attempt at a time: attempt.ready stays low from acceptance until the verdict is loaded;
// a verdict held by the sink stalls the write-back and the next attempt until it is taken.
// Reset: synchronous; clears all entries (valid bits), restores rate_limit 8, window 60.
`timescale 1ns / 1ps
`default_nettype none

module per_peer_connection_rate_limiter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire prl_pkg::cfg_idx_t  cfg_index,
  input  wire prl_pkg::cfg_data_t cfg_data,
  prl_attempt_if.sink             attempt,
  prl_verdict_if.source           verdict
);
  import prl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   rate_limit;
  logic [WINDOW_W-1:0]  window_seconds;

  // Captured attempt
  logic [ADDR_W-1:0]    peer;
  logic [TIME_W-1:0]    now;

  // Scan bookkeeping
  scan_cnt_t            rd_cnt;
  logic                 chk_vld;
  idx_t                 chk_idx;
  logic                 have_empty;
  idx_t                 empty_idx;
  logic                 have_match;
  idx_t                 m_idx;
  logic [COUNT_W-1:0]   m_cnt;
  logic [TIME_W-1:0]    m_start;
  logic [TIME_W-1:0]    min_start;
  idx_t                 min_idx;

  // Output register
  logic                 out_valid;
  logic                 out_allowed;
  outcome_t             out_outcome;

  tbl_req_t             req;
  entry_t               rd_entry;
  entry_t               wr_data;

  logic                 accept;
  logic                 rd_en;
  logic                 is_empty;
  logic                 hit;
  logic                 scan_last;
  logic                 scan_done;
  logic                 fin_go;

  logic                 dec_wr;
  idx_t                 dec_idx;
  entry_t               dec_entry;
  logic                 dec_allowed;
  outcome_t             dec_outcome;
  logic [TIME_W-1:0]    elapsed;

  prl_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr_data  (wr_data),
    .rd_entry (rd_entry)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit     <= RATE_LIMIT_RST;
      window_seconds <= WINDOW_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RATE_LIMIT: rate_limit     <= cfg_data[COUNT_W-1:0];
        REG_WINDOW:     window_seconds <= cfg_data[WINDOW_W-1:0];
        default:        ;
      endcase
    end
  end

  // Handshake and scan control
  assign attempt.ready = (state == ST_IDLE) && !rst;
  assign accept        = attempt.valid && attempt.ready;
  assign rd_en         = (state == ST_SCAN) && (rd_cnt < SCAN_END);
  assign is_empty      = (rd_entry.address == '0) && (rd_entry.count == '0);
  assign hit           = chk_vld && !is_empty && (rd_entry.address == peer);
  assign scan_last     = chk_vld && (chk_idx == LAST_IDX);
  assign scan_done     = hit || scan_last;
  assign fin_go        = (state == ST_FIN) && (!out_valid || verdict.ready);

  // Decide the update for the chosen entry
  assign elapsed = now - m_start;

  always_comb begin
    dec_wr      = 1'b1;
    dec_idx     = m_idx;
    dec_entry   = '{address: peer, count: COUNT_W'(1), window_start: now};
    dec_allowed = 1'b1;
    dec_outcome = OUT_COUNTED;
    if (!have_match && !have_empty) begin
      dec_idx     = min_idx;
      dec_outcome = OUT_EVICT;
    end else if (!have_match) begin
      dec_idx     = empty_idx;
      dec_outcome = OUT_NEW;
    end else if (m_start == '0) begin
      dec_outcome = OUT_RESTART;
    end else if (elapsed >= TIME_W'(window_seconds)) begin
      dec_outcome = OUT_RESTART;
    end else if (m_cnt >= rate_limit) begin
      dec_wr      = 1'b0;
      dec_allowed = 1'b0;
      dec_outcome = OUT_REJECT;
    end else begin
      dec_entry   = '{address: peer, count: m_cnt + COUNT_W'(1), window_start: m_start};
      dec_outcome = OUT_COUNTED;
    end
  end

  // Table requests
  always_comb begin
    req.rd_en  = rd_en;
    req.rd_idx = rd_cnt[IDX_W-1:0];
    req.wr_en  = fin_go && dec_wr;
    req.wr_idx = dec_idx;
  end
  assign wr_data = dec_entry;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chk_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          chk_vld <= 1'b0;
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_vld <= rd_en && !scan_done;
          if (scan_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          chk_vld <= 1'b0;
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state   <= ST_IDLE;
          chk_vld <= 1'b0;
        end
      endcase
    end
  end

  // Scan pointer and match/empty/oldest tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt     <= '0;
      have_empty <= 1'b0;
      have_match <= 1'b0;
    end else if (accept) begin
      rd_cnt     <= '0;
      have_empty <= 1'b0;
      have_match <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_cnt <= rd_cnt + scan_cnt_t'(1);
      end
      if (chk_vld && state == ST_SCAN) begin
        if (is_empty && !have_empty) begin
          have_empty <= 1'b1;
          empty_idx  <= chk_idx;
        end
        if (hit) begin
          have_match <= 1'b1;
          m_idx      <= chk_idx;
          m_cnt      <= rd_entry.count;
          m_start    <= rd_entry.window_start;
        end
        if (chk_idx == '0 || rd_entry.window_start < min_start) begin
          min_start <= rd_entry.window_start;
          min_idx   <= chk_idx;
        end
      end
    end
  end

  // Track which entry the read data belongs to; capture the attempt
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= rd_cnt[IDX_W-1:0];
    end
    if (accept) begin
      peer <= attempt.peer_ip;
      now  <= attempt.now_seconds;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_allowed <= dec_allowed;
      out_outcome <= dec_outcome;
    end
  end

  assign verdict.valid   = out_valid;
  assign verdict.allowed = out_allowed;
  assign verdict.outcome = out_outcome;

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted attempt did not start a scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= SCAN_END)
    else $error("scan pointer ran past the table");

  a_check_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> state == ST_SCAN)
    else $error("read data checked outside the scan");

  a_fin_loads_verdict: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> verdict.valid)
    else $error("finished attempt produced no verdict");

  a_allowed_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (verdict.allowed == (verdict.outcome != OUT_REJECT)))
    else $error("allowed flag disagrees with outcome");

endmodule

`default_nettype wire

[tb/per_peer_connection_rate_limiter_tb.sv]
// Self-checking testbench for the per-peer connection rate limiter.
// Depends on prl_pkg, the prl_attempt_if / prl_verdict_if interfaces and the block itself;
// a table model predicts every verdict, which is checked in order of arrival.
`timescale 1ns / 1ps

module per_peer_connection_rate_limiter_tb;
  import prl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned POOL_MAX    = 128;
  localparam int unsigned OUTCOMES    = 5;

  // Spare register indexes beyond the two real registers; writes to them are ignored
  localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_HI = cfg_idx_t'(3);

  typedef struct packed {
    logic     allowed;
    outcome_t outcome;
  } verdict_t;

  // Table model of the limiter plus the queue of verdicts still owed by the block
  class verdict_ledger;
    logic [COUNT_W-1:0]  limit;
    logic [WINDOW_W-1:0] window;
    logic [ADDR_W-1:0]   peer_of   [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  hits_of   [TABLE_ENTRIES];
    logic [TIME_W-1:0]   opened_at [TABLE_ENTRIES];
    verdict_t            owed_verdicts[$];
    int unsigned         checked;
    int unsigned         errors;
    int unsigned         tally[OUTCOMES];

    function new();
      limit   = RATE_LIMIT_RST;
      window  = WINDOW_RST;
      checked = 0;
      errors  = 0;
      foreach (tally[k]) tally[k] = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        peer_of[i]   = '0;
        hits_of[i]   = '0;
        opened_at[i] = '0;
      end
    endfunction

    function void write_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_RATE_LIMIT: limit  = data[COUNT_W-1:0];
        REG_WINDOW:     window = data[WINDOW_W-1:0];
        default: ;
      endcase
    endfunction

    // Restart an entry for this peer with a fresh window
    function void claim(int slot, logic [ADDR_W-1:0] peer, logic [TIME_W-1:0] now);
      peer_of[slot]   = peer;
      opened_at[slot] = now;
      hits_of[slot]   = 1;
    endfunction

    // Work out the verdict of one accepted attempt and update the table
    function void log_attempt(logic [ADDR_W-1:0] peer, logic [TIME_W-1:0] now);
      int       slot;
      int       free_slot;
      bit       hit;
      bit       has_free;
      verdict_t v;
      slot      = 0;
      free_slot = 0;
      hit       = 0;
      has_free  = 0;
      // Single scan: first matching live entry wins, else remember the first empty one
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (peer_of[i] == '0 && hits_of[i] == '0) begin
          if (!has_free) begin
            has_free  = 1;
            free_slot = i;
          end
        end else if (peer_of[i] == peer) begin
          hit  = 1;
          slot = i;
          break;
        end
      end

      if (!hit && !has_free) begin
        // Table full: evict the first entry with the oldest window start
        slot = 0;
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
          if (opened_at[i] < opened_at[slot]) slot = i;
        end
        claim(slot, peer, now);
        v = '{allowed: 1'b1, outcome: OUT_EVICT};
      end else if (!hit) begin
        claim(free_slot, peer, now);
        v = '{allowed: 1'b1, outcome: OUT_NEW};
      end else if (opened_at[slot] == '0) begin
        claim(slot, peer, now);
        v = '{allowed: 1'b1, outcome: OUT_RESTART};
      end else if (now - opened_at[slot] >= TIME_W'(window)) begin
        opened_at[slot] = now;
        hits_of[slot]   = 1;
        v = '{allowed: 1'b1, outcome: OUT_RESTART};
      end else if (hits_of[slot] >= limit) begin
        v = '{allowed: 1'b0, outcome: OUT_REJECT};
      end else begin
        hits_of[slot] = hits_of[slot] + 1'b1;
        v = '{allowed: 1'b1, outcome: OUT_COUNTED};
      end
      owed_verdicts.push_back(v);
    endfunction

    // Compare one verdict beat with the oldest owed verdict
    function void match_verdict(logic allowed, logic [OUT_W-1:0] outcome);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        $error("verdict beat with no attempt outstanding: allowed %0d outcome %0d",
               allowed, outcome);
        errors++;
        return;
      end
      want = owed_verdicts.pop_front();
      checked++;
      tally[int'(want.outcome)]++;
      if (allowed !== want.allowed) begin
        $error("allowed mismatch: expected %0d, actual %0d", want.allowed, allowed);
        errors++;
      end
      if (outcome !== want.outcome) begin
        $error("outcome mismatch: expected %0d, actual %0d", want.outcome, outcome);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_verdicts.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_write;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  prl_attempt_if attempt_ch ();
  prl_verdict_if verdict_ch ();

  per_peer_connection_rate_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .attempt   (attempt_ch),
    .verdict   (verdict_ch)
  );

  verdict_ledger ledger = new();

  int unsigned       burst_left;
  int unsigned       attempts_sent;
  int unsigned       settings_used;
  int unsigned       cycle_count;
  int unsigned       pool_fill;
  logic [ADDR_W-1:0] peer_pool [POOL_MAX];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check every verdict beat
  always @(posedge clk) begin
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      ledger.match_verdict(verdict_ch.allowed, verdict_ch.outcome);
    end
  end

  // Verdict back-pressure: rotating stall patterns, plus one long hold-off
  initial begin
    int unsigned tick;
    logic [15:0] pattern;
    bit          held;
    tick    = 0;
    pattern = '1;
    held    = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && ledger.checked >= 250) begin
        held = 1;
        verdict_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (tick % 128 == 0) begin
        case ($urandom_range(3))
          0:       pattern = '1;
          1:       pattern = 16'($urandom);
          2:       pattern = 16'h0101;
          default: pattern = 16'hF0F0;
        endcase
      end
      verdict_ch.ready <= pattern[tick % 16];
      tick++;
    end
  end

  function automatic logic [ADDR_W-1:0] fresh_peer();
    logic [ADDR_W-1:0] p;
    p = $urandom;
    if (p == '0) p = 1;
    return p;
  endfunction

  // Drop valid and wait out the pause given by n; a zero n does nothing
  task automatic pause(int unsigned n);
    if (n > 0) begin
      attempt_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one attempt in bursts of random length and wait for its beat
  task automatic offer(logic [ADDR_W-1:0] peer, logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(3) != 0) pause($urandom_range(1, 20));
    end
    burst_left--;
    attempt_ch.valid       <= 1'b1;
    attempt_ch.peer_ip     <= peer;
    attempt_ch.now_seconds <= now;
    @(posedge clk);
    while (!attempt_ch.ready) @(posedge clk);
    ledger.log_attempt(peer, now);
    attempts_sent++;
  endtask

  // Stop offering and wait until every owed verdict has arrived
  task automatic wait_drained();
    attempt_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    ledger.write_register(idx, data);
  endtask

  // Write both registers back to back, optionally poking a spare index first
  task automatic apply_settings(cfg_data_t limit_word, cfg_data_t window_word, bit spare);
    if (spare) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    write_reg(REG_RATE_LIMIT, limit_word);
    write_reg(REG_WINDOW, window_word);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // One random phase: new settings, a pool of peers and a wandering clock
  task automatic run_phase(int unsigned limit, int unsigned window, int unsigned pool_size,
                           int unsigned n_items);
    logic [TIME_W-1:0] clock_now;
    int unsigned       r;
    wait_drained();
    apply_settings({8'($urandom), 8'(limit)}, 16'(window), $urandom_range(1));
    // Keep some peers from the last pool so leftover entries get matched
    for (int i = 0; i < pool_size; i++) begin
      if (!(i < pool_fill && $urandom_range(1))) peer_pool[i] = fresh_peer();
    end
    pool_fill = pool_size;
    case ($urandom_range(3))
      0:       clock_now = '0;
      1:       clock_now = TIME_W'($urandom_range(1000));
      2:       clock_now = {$urandom, $urandom};
      default: clock_now = '1 - TIME_W'($urandom_range(3 * window));
    endcase
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 35) begin
        // same second
      end else if (r < 65) begin
        clock_now += TIME_W'($urandom_range(window));
      end else if (r < 80) begin
        clock_now += TIME_W'(window - 1 + $urandom_range(2));
      end else if (r < 89) begin
        clock_now += TIME_W'($urandom_range(3 * window));
      end else if (r < 95) begin
        clock_now -= TIME_W'($urandom_range(window));
      end else if (r < 97) begin
        clock_now = '0;
      end else begin
        clock_now = {$urandom, $urandom};
      end
      offer(peer_pool[$urandom_range(pool_size - 1)], clock_now);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] peer_a;
    logic [ADDR_W-1:0] peer_b;
    logic [ADDR_W-1:0] peer_c;
    peer_a        = 32'h0A00_0001;
    peer_b        = 32'h8000_0000;
    peer_c        = 32'h5555_5555;
    burst_left    = 0;
    attempts_sent = 0;
    settings_used = 0;
    cycle_count   = 0;
    pool_fill     = 0;

    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_index              <= REG_RATE_LIMIT;
    cfg_data               <= '0;
    attempt_ch.valid       <= 1'b0;
    attempt_ch.peer_ip     <= '0;
    attempt_ch.now_seconds <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: limit 2 written with junk in the upper byte, window 60
    apply_settings(16'h0102, 16'd60, 1'b1);
    offer(peer_a, 64'd0);          // new entry, window start zero
    offer(peer_a, 64'd5);          // zero window start forces a restart
    offer(peer_a, 64'd6);          // counted
    offer(peer_a, 64'd7);          // rejected at the limit
    offer(peer_a, 64'd65);         // difference equals the window: restart
    offer(peer_a, 64'd124);        // one second short of expiry: counted
    offer(peer_a, 64'd124);        // rejected
    offer(peer_a, 64'd100);        // clock went backwards: wrapped difference restarts
    offer('1, '1);                 // largest peer at the last second
    offer('1, 64'd10);             // wrapped difference of 11: counted
    offer(32'd1, 64'h8000_0000_0000_0000);
    offer(32'd1, 64'd0);           // half-range difference restarts
    offer(peer_b, 64'd0);          // new entry at time zero
    offer(peer_b, 64'd0);          // restart with start still zero
    offer(peer_b, 64'd0);

    // Directed: widest limit and window
    wait_drained();
    apply_settings(16'h00FF, 16'hFFFF, 1'b0);
    offer(peer_c, 64'd1000);
    offer(peer_c, 64'd66534);      // just inside the window
    offer(peer_c, 64'd66535);      // exactly at the window length

    // Directed: narrowest limit and window
    wait_drained();
    apply_settings(16'h0001, 16'h0001, 1'b0);
    offer(peer_c, 64'd66535);      // live window, limit already reached
    offer(peer_c, 64'd66536);      // one second later: restart
    offer(32'hAAAA_AAAA, 64'd5);

    // Random phases, extremes of the registers among them
    run_phase(1, 1, 6, 160);
    run_phase(255, 65535, 12, 160);
    run_phase(8, 60, 40, 160);
    run_phase(2, 10, 100, 160);
    run_phase(255, 1, 20, 160);
    run_phase(1, 65535, 70, 160);
    run_phase($urandom_range(1, 255), $urandom_range(1, 65535), $urandom_range(4, 96), 160);
    run_phase($urandom_range(1, 255), $urandom_range(1, 300), $urandom_range(4, 96), 160);

    // Drain, then leave room for any stray verdict
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Sent %0d connection attempts under %0d register settings, with one long verdict stall.",
             attempts_sent, settings_used);
    $display("Verdicts checked: %0d new, %0d evicted, %0d restarted, %0d counted, %0d rejected.",
             ledger.tally[OUT_NEW], ledger.tally[OUT_EVICT], ledger.tally[OUT_RESTART],
             ledger.tally[OUT_COUNTED], ledger.tally[OUT_REJECT]);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
sv/prl_pkg.sv
sv/prl_if.sv
sv/prl_table.sv
sv/per_peer_connection_rate_limiter.sv
tb/per_peer_connection_rate_limiter_tb.sv
